// ===== sv/bia_pkg.sv =====
// Shared types and constants for the bitmap index allocator.
// Used by bitmap_index_allocator and the testbench; depends on nothing.
package bia_pkg;

	localparam int ENTRIES_DEF = 256;
	localparam int IDX_W       = 8;
	localparam int WORD_W      = 32;
	localparam int BIT_W       = 5;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_INVALID   = 2'd2,
		ST_PROTECTED = 2'd3
	} status_t;

	typedef struct packed {
		action_t            action;
		logic [IDX_W-1:0]   entry_index;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   granted_index;
		logic [IDX_W-1:0]   free_entries;
	} rsp_t;

endpackage

// ===== sv/bia_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; contents are undefined until written.
module bia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/bitmap_index_allocator.sv =====
// First-fit allocator over an in-use bitmap held in 32-bit words of a RAM.
// Depends on bia_pkg and bia_ram.
// A free refused on its index, or an allocate on a full map, is answered directly from idle; any
// other free reads its map word and then clears the bit if set; an allocate scans words 0 up to
// NWORDS-1 (one RAM read a cycle) until a clear bit. busy falls with done, so the next transfer can be
// taken in the done cycle; the receiver cannot stall. Reset: a clearing pass over every map word
// writes the map, busy high.
module bitmap_index_allocator #(
	parameter int ENTRIES = bia_pkg::ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bia_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output bia_pkg::rsp_t rsp
);

	localparam int SPAN      = (ENTRIES < 256) ? ENTRIES : 256;
	localparam int NWORDS    = (SPAN + bia_pkg::WORD_W - 1) / bia_pkg::WORD_W;
	localparam int WA_W      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int LAST_BITS = SPAN - (NWORDS - 1) * bia_pkg::WORD_W;
	localparam logic [bia_pkg::WORD_W-1:0] LAST_MASK =
		~({bia_pkg::WORD_W{1'b1}} >> (bia_pkg::WORD_W - LAST_BITS));
	localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NWORDS - 1);
	localparam logic [bia_pkg::IDX_W-1:0] CNT_RST = bia_pkg::IDX_W'(SPAN - 2);
	localparam logic [bia_pkg::WORD_W-1:0] WORD0_RST = bia_pkg::WORD_W'(3);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL
	} state_t;

	state_t                       state_q;
	logic [WA_W-1:0]              clr_q;
	logic [WA_W-1:0]              ptr_q;
	bia_pkg::req_t                req_q;
	logic [bia_pkg::IDX_W-1:0]    free_cnt_q;
	logic                         done_q;
	bia_pkg::rsp_t                rsp_q;

	logic                         ram_we;
	logic [WA_W-1:0]              ram_waddr;
	logic [bia_pkg::WORD_W-1:0]   ram_wdata;
	logic                         ram_re;
	logic [WA_W-1:0]              ram_raddr;
	logic [bia_pkg::WORD_W-1:0]   ram_rdata;

	logic [bia_pkg::WORD_W-1:0]   masked;
	logic                         found;
	logic [bia_pkg::BIT_W-1:0]    pos;
	logic                         in_bad;
	logic                         in_prot;
	logic [bia_pkg::BIT_W-1:0]    q_bit;
	logic                         q_used;
	logic [bia_pkg::IDX_W-1:0]    grant_idx;

	bia_ram #(
		.WIDTH(bia_pkg::WORD_W),
		.DEPTH(NWORDS),
		.AW   (WA_W)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		// bits past the managed span read as taken
		masked = ram_rdata | ((ptr_q == LAST_WORD) ? LAST_MASK : '0);
		found  = 1'b0;
		pos    = '0;
		for (int b = bia_pkg::WORD_W - 1; b >= 0; b--) begin
			if (!masked[b]) begin
				found = 1'b1;
				pos   = bia_pkg::BIT_W'(b);
			end
		end
		grant_idx = (bia_pkg::IDX_W'(ptr_q) << bia_pkg::BIT_W) | bia_pkg::IDX_W'(pos);

		in_bad  = (req.entry_index == '0) ||
			({1'b0, req.entry_index} >= 9'(SPAN));
		in_prot = (req.entry_index == bia_pkg::IDX_W'(1));
		q_bit   = req_q.entry_index[bia_pkg::BIT_W-1:0];
		q_used  = ram_rdata[q_bit];

		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;

		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = (clr_q == '0) ? WORD0_RST : '0;
			end
			S_IDLE: begin
				if (start) begin
					if (req.action == bia_pkg::ACT_FREE) begin
						ram_re    = !in_bad && !in_prot;
						ram_raddr = req.entry_index[bia_pkg::BIT_W +: WA_W];
					end else begin
						ram_re    = (free_cnt_q != '0);
						ram_raddr = '0;
					end
				end
			end
			S_EVAL: begin
				if (req_q.action == bia_pkg::ACT_FREE) begin
					ram_we    = q_used;
					ram_waddr = req_q.entry_index[bia_pkg::BIT_W +: WA_W];
					ram_wdata = ram_rdata & ~(bia_pkg::WORD_W'(1) << q_bit);
				end else if (found) begin
					ram_we    = 1'b1;
					ram_waddr = ptr_q;
					ram_wdata = ram_rdata | (bia_pkg::WORD_W'(1) << pos);
				end else if (ptr_q != LAST_WORD) begin
					ram_re    = 1'b1;
					ram_raddr = WA_W'(ptr_q + 1'b1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			ptr_q      <= '0;
			req_q      <= '0;
			free_cnt_q <= CNT_RST;
			done_q     <= 1'b0;
			rsp_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= WA_W'(clr_q + 1'b1);
					if (clr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						ptr_q <= '0;
						rsp_q.granted_index <= '0;
						rsp_q.free_entries  <= free_cnt_q;
						if (req.action == bia_pkg::ACT_FREE) begin
							if (in_bad) begin
								done_q       <= 1'b1;
								rsp_q.status <= bia_pkg::ST_INVALID;
							end else if (in_prot) begin
								done_q       <= 1'b1;
								rsp_q.status <= bia_pkg::ST_PROTECTED;
							end else begin
								state_q <= S_EVAL;
							end
						end else if (free_cnt_q == '0) begin
							done_q       <= 1'b1;
							rsp_q.status <= bia_pkg::ST_NO_SPACE;
						end else begin
							state_q <= S_EVAL;
						end
					end
				end
				S_EVAL: begin
					if (req_q.action == bia_pkg::ACT_FREE) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (q_used) begin
							free_cnt_q         <= free_cnt_q + 1'b1;
							rsp_q.status       <= bia_pkg::ST_OK;
							rsp_q.free_entries <= free_cnt_q + 1'b1;
						end else begin
							rsp_q.status <= bia_pkg::ST_INVALID;
						end
					end else if (found) begin
						done_q              <= 1'b1;
						state_q             <= S_IDLE;
						free_cnt_q          <= free_cnt_q - 1'b1;
						rsp_q.status        <= bia_pkg::ST_OK;
						rsp_q.granted_index <= grant_idx;
						rsp_q.free_entries  <= free_cnt_q - 1'b1;
					end else if (ptr_q == LAST_WORD) begin
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
						rsp_q.status <= bia_pkg::ST_NO_SPACE;
					end else begin
						// advance to the next map word
						ptr_q <= WA_W'(ptr_q + 1'b1);
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= CNT_RST)
		else $error("free count above span");

	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.granted_index != '0 |->
			rsp.granted_index >= bia_pkg::IDX_W'(2) && rsp.status == bia_pkg::ST_OK)
		else $error("bad granted index");

	a_no_space_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == bia_pkg::ST_NO_SPACE |-> rsp.free_entries == '0)
		else $error("no_space reported with free entries left");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q != S_IDLE)
		else $error("map write while idle");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("transfer accepted without progress");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_index_allocator: allocate/free requests, rejects, full map.
// Depends on bia_pkg and the allocator RTL; an in-bench tracker of the in-use map predicts replies.
module testbench;
	import bia_pkg::*;

	localparam int SPAN         = (ENTRIES_DEF < 256) ? ENTRIES_DEF : 256;
	localparam int RANDOM_ITEMS = 1550;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;

	typedef enum int {
		PH_FILL,
		PH_DRAIN,
		PH_MIX
	} phase_t;

	// Mirror of the in-use map and free count; holds the replies still owed by the block.
	class alloc_tracker;
		bit          in_use[256];
		int unsigned free_cnt;
		rsp_t        expected_replies[$];
		int          errors;

		function new();
			foreach (in_use[i]) in_use[i] = 1'b0;
			in_use[0] = 1'b1;
			in_use[1] = 1'b1;
			free_cnt  = SPAN - 2;
			errors    = 0;
		endfunction

		function void log_request(req_t r);
			rsp_t want;
			bit   found;
			want.status        = ST_OK;
			want.granted_index = '0;
			found              = 1'b0;
			if (r.action == ACT_ALLOC) begin
				if (free_cnt == 0) begin
					want.status = ST_NO_SPACE;
				end else begin
					// first fit: lowest clear entry above 0
					for (int i = 1; i < SPAN && !found; i++) begin
						if (!in_use[i]) begin
							in_use[i]          = 1'b1;
							free_cnt--;
							want.granted_index = 8'(i);
							found              = 1'b1;
						end
					end
					if (!found) want.status = ST_NO_SPACE;
				end
			end else if (r.entry_index == 0 || r.entry_index >= SPAN) begin
				want.status = ST_INVALID;
			end else if (r.entry_index == 1) begin
				want.status = ST_PROTECTED;
			end else if (!in_use[r.entry_index]) begin
				want.status = ST_INVALID;
			end else begin
				in_use[r.entry_index] = 1'b0;
				free_cnt++;
			end
			want.free_entries = 8'(free_cnt);
			expected_replies.push_back(want);
		endfunction

		function void check_reply(rsp_t got);
			rsp_t want;
			if (expected_replies.size() == 0) begin
				$error("unexpected reply: status %0d, granted_index %0d, free_entries %0d",
					got.status, got.granted_index, got.free_entries);
				errors++;
				return;
			end
			want = expected_replies.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.granted_index !== want.granted_index) begin
				$error("granted_index: expected %0d, got %0d", want.granted_index,
					got.granted_index);
				errors++;
			end
			if (got.free_entries !== want.free_entries) begin
				$error("free_entries: expected %0d, got %0d", want.free_entries,
					got.free_entries);
				errors++;
			end
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n;
	logic  start;
	req_t  req;
	logic  busy;
	logic  done;
	rsp_t  rsp;

	alloc_tracker tracker = new();
	int    sent;
	int    cycles;
	bit    no_gaps;

	bitmap_index_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("bitmap_index_allocator verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) tracker.check_reply(rsp);
	end

	// Hold start high until the block takes the transfer; keep it high for a back-to-back item.
	task automatic send_request(input action_t act, input logic [IDX_W-1:0] idx);
		int   gap;
		req_t item;
		gap              = no_gaps ? 0 : $urandom_range(0, 7);
		item.action      = act;
		item.entry_index = idx;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= item;
		do @(posedge clk); while (busy);
		tracker.log_request(item);
		sent++;
	endtask

	function automatic logic [IDX_W-1:0] pick_used();
		int pool[$];
		for (int i = 2; i < SPAN; i++) begin
			if (tracker.in_use[i]) pool.push_back(i);
		end
		if (pool.size() == 0) return 8'($urandom_range(0, 255));
		return 8'(pool[$urandom_range(0, pool.size() - 1)]);
	endfunction

	task automatic send_any_free();
		send_request(ACT_FREE, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_alloc();
		send_request(ACT_ALLOC, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		phase_t phase;
		int     target;
		int     extra;
		int     len;
		int     roll;

		arst_n  = 1'b0;
		start   = 1'b0;
		req     = '0;
		sent    = 0;
		no_gaps = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: first fit, reserved and protected entries, double free, refill of a hole
		send_request(ACT_ALLOC, 8'h00);
		send_request(ACT_ALLOC, 8'hFF);
		send_request(ACT_FREE, 8'd0);
		send_request(ACT_FREE, 8'd1);
		send_request(ACT_FREE, 8'd255);
		send_request(ACT_FREE, 8'd2);
		send_request(ACT_FREE, 8'd2);
		send_request(ACT_ALLOC, 8'h55);
		send_request(ACT_ALLOC, 8'hAA);
		send_request(ACT_FREE, 8'd128);
		send_request(ACT_FREE, 8'd3);
		send_request(ACT_ALLOC, 8'h00);
		send_request(ACT_FREE, 8'd4);
		send_request(ACT_FREE, 8'd3);
		send_request(ACT_FREE, 8'd2);
		send_request(ACT_FREE, 8'd2);

		target = sent + RANDOM_ITEMS;
		while (sent < target) begin
			roll    = $urandom_range(0, 99);
			phase   = (roll < 35) ? PH_FILL : (roll < 70) ? PH_DRAIN : PH_MIX;
			no_gaps = ($urandom_range(0, 3) == 0);
			case (phase)
				PH_FILL: begin
					// run the map to full, then hammer it a few times more
					extra = $urandom_range(2, 8);
					while (sent < target && extra > 0) begin
						if ($urandom_range(0, 9) == 0) send_any_free();
						else send_alloc();
						if (tracker.free_cnt == 0) extra--;
					end
				end
				PH_DRAIN: begin
					len = $urandom_range(20, 250);
					while (sent < target && len > 0) begin
						roll = $urandom_range(0, 99);
						if (roll < 75) send_request(ACT_FREE, pick_used());
						else if (roll < 85) send_any_free();
						else send_alloc();
						len--;
					end
				end
				default: begin
					len = $urandom_range(20, 200);
					while (sent < target && len > 0) begin
						roll = $urandom_range(0, 99);
						if (roll < 50) send_alloc();
						else if (roll < 75) send_request(ACT_FREE, pick_used());
						else send_any_free();
						len--;
					end
				end
			endcase
		end
		start <= 1'b0;

		while (tracker.expected_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("bitmap_index_allocator verification clean");
		end else begin
			$display("bitmap_index_allocator verification failed");
		end
		$finish;
	end

endmodule
